// ===== rtl/rgbyuv_pkg.sv =====
// Shared types and constants for the RGB to YCbCr 4:2:0 converter.
// No dependencies; imported by every module of the block except rgbyuv_ram.
package rgbyuv_pkg;

  // configuration register port
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // BT.601 integer coefficients (magnitudes; signs are applied in the datapath)
  localparam int Y_KR = 66;
  localparam int Y_KG = 129;
  localparam int Y_KB = 25;
  localparam int ROUND = 128;
  localparam int Y_OFS = 16;
  localparam int CB_KR = 38;
  localparam int CB_KG = 74;
  localparam int CB_KB = 112;
  localparam int CR_KR = 112;
  localparam int CR_KG = 94;
  localparam int CR_KB = 18;
  // rounding plus the 128 offset pre-shifted by 8, keeps the sum non-negative
  localparam int CHROMA_BIAS = 128 + 32768;

  typedef logic [7:0] comp_t;

  // sums of a horizontal pixel pair, one per channel
  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
  } psum_t;

  // input register contents handed to the color datapath
  typedef struct packed {
    logic  valid;
    comp_t red;
    comp_t green;
    comp_t blue;
    psum_t psum;
    logic  chroma_ok;
    logic  eof;
  } stage1_t;

endpackage

// ===== rtl/rgbyuv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgbyuv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rgbyuv_ctrl.sv =====
// Front end: config registers, raster counters, input register and the
// even-row pair-sum line store. Depends on rgbyuv_pkg and rgbyuv_ram.
module rgbyuv_ctrl
  import rgbyuv_pkg::*;
#(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  comp_t                red,
  input  comp_t                green,
  input  comp_t                blue,
  input  logic                 s1_take,
  output stage1_t              s1,
  output psum_t                line_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int WXW = (CFG_W > CW + 1) ? CFG_W : CW + 1;
  localparam int HXW = (CFG_W > RW + 1) ? CFG_W : RW + 1;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [CW-1:0]    column_count;
  logic [RW-1:0]    row_count;
  comp_t            hold_r, hold_g, hold_b;

  logic [WXW-1:0] width_ext;
  logic [HXW-1:0] height_ext;
  logic [CW-1:0]  last_col;
  logic [RW-1:0]  last_row;
  logic           accept, row_end, frame_end, odd_col, odd_row;
  psum_t          pair;
  logic [AW-1:0]  slot;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  assign width_ext  = WXW'(frame_width);
  assign height_ext = HXW'(frame_height);
  assign last_col = (width_ext == '0) ? '0 :
                    (width_ext > WXW'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) :
                    CW'(width_ext - WXW'(1));
  assign last_row = (height_ext == '0) ? '0 :
                    (height_ext > HXW'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1) :
                    RW'(height_ext - HXW'(1));

  assign in_stall  = s1.valid && !s1_take;
  assign accept    = in_valid && !in_stall;
  assign row_end   = column_count >= last_col;
  assign frame_end = row_end && (row_count >= last_row);
  assign odd_col   = column_count[0];
  assign odd_row   = row_count[0];
  assign slot      = AW'(column_count >> 1);

  assign pair.r = {1'b0, hold_r} + {1'b0, red};
  assign pair.g = {1'b0, hold_g} + {1'b0, green};
  assign pair.b = {1'b0, hold_b} + {1'b0, blue};

  // counters, left-pixel hold and the input register with its payload
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      hold_r       <= '0;
      hold_g       <= '0;
      hold_b       <= '0;
      s1.valid     <= 1'b0;
    end else begin
      if (accept) begin
        s1.valid     <= 1'b1;
        s1.red       <= red;
        s1.green     <= green;
        s1.blue      <= blue;
        s1.psum      <= pair;
        s1.chroma_ok <= odd_col && odd_row;
        s1.eof       <= frame_end;
        if (!odd_col) begin
          hold_r <= red;
          hold_g <= green;
          hold_b <= blue;
        end
        if (row_end) begin
          column_count <= '0;
          row_count    <= frame_end ? '0 : row_count + RW'(1);
        end else begin
          column_count <= column_count + CW'(1);
        end
      end else if (s1_take) begin
        s1.valid <= 1'b0;
      end
    end
  end

  // even rows store pair sums, odd rows fetch them alongside the input register
  rgbyuv_ram #(
    .WIDTH($bits(psum_t)),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk    (clk),
    .wr_en  (accept && odd_col && !odd_row),
    .wr_addr(slot),
    .wr_data(pair),
    .rd_en  (accept && odd_col && odd_row),
    .rd_addr(slot),
    .rd_data(line_data)
  );

endmodule

// ===== rtl/rgbyuv_color.sv =====
// Color datapath: luma and block averages, then chroma and the output register.
// Depends on rgbyuv_pkg.
module rgbyuv_color
  import rgbyuv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  stage1_t s1,
  input  psum_t   line_data,
  output logic    s1_take,
  output logic    out_valid,
  input  logic    out_stall,
  output comp_t   luma,
  output logic    chroma_valid,
  output comp_t   cb,
  output comp_t   cr,
  output logic    end_of_frame
);

  logic        s2_valid, s2_take, s2_cv, s2_eof;
  comp_t       s2_luma, s2_ar, s2_ag, s2_ab;
  logic [15:0] luma_acc;
  logic [9:0]  quad_r, quad_g, quad_b;
  logic [16:0] cb_acc, cr_acc;

  assign s2_take = !out_valid || !out_stall;
  assign s1_take = !s2_valid || s2_take;

  assign luma_acc = 16'(Y_KR * int'(s1.red) + Y_KG * int'(s1.green)
                        + Y_KB * int'(s1.blue) + ROUND);
  assign quad_r = {1'b0, s1.psum.r} + {1'b0, line_data.r};
  assign quad_g = {1'b0, s1.psum.g} + {1'b0, line_data.g};
  assign quad_b = {1'b0, s1.psum.b} + {1'b0, line_data.b};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_take) begin
      s2_valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s2_luma <= 8'(luma_acc[15:8] + 8'(Y_OFS));
      s2_ar   <= quad_r[9:2];
      s2_ag   <= quad_g[9:2];
      s2_ab   <= quad_b[9:2];
      s2_cv   <= s1.chroma_ok;
      s2_eof  <= s1.eof;
    end
  end

  // bias keeps both sums in 0..65535
  assign cb_acc = 17'(CB_KB * int'(s2_ab) + CHROMA_BIAS
                      - CB_KR * int'(s2_ar) - CB_KG * int'(s2_ag));
  assign cr_acc = 17'(CR_KR * int'(s2_ar) + CHROMA_BIAS
                      - CR_KG * int'(s2_ag) - CR_KB * int'(s2_ab));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_take) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      luma         <= s2_luma;
      chroma_valid <= s2_cv;
      cb           <= s2_cv ? cb_acc[15:8] : '0;
      cr           <= s2_cv ? cr_acc[15:8] : '0;
      end_of_frame <= s2_eof;
    end
  end

endmodule

// ===== rtl/rgb_to_yuv420_converter.sv =====
// Top level of the streaming RGB to YCbCr 4:2:0 converter.
// Depends on rgbyuv_pkg, rgbyuv_ctrl, rgbyuv_color (and rgbyuv_ram below it).
//
// Usage:
//   Input channel (in_valid / in_stall, red/green/blue): one RGB pixel per
//   request, raster order. Output channel (out_valid / out_stall): one
//   request per pixel carrying luma, and on the bottom-right pixel of every
//   complete 2x2 block chroma_valid with cb/cr (otherwise cb/cr are 0).
//   end_of_frame marks the last pixel of each frame.
//   Config port: cfg_write with cfg_index 0 = frame_width, 1 = frame_height.
//   Write only while the pipeline is empty.
// Timing:
//   Three-stage pipeline: input register (with the line-store read), luma
//   and 2x2 averages, chroma and output register. An accepted pixel passes
//   through the input register, the luma/average register and the output
//   register in order. One pixel per clock while out_stall is low; the only
//   memory is the single line store, one write or one read per pixel pair.
// Reset (rst, synchronous): counters, left-pixel hold and all valid flags
//   clear, geometry returns to 640x480. The line store is not cleared; an
//   odd row only reads entries written by the even row above it.
// Stall: when out_stall holds, the output request stays put, the inner
//   stages keep filling, and in_stall rises only once every stage is full.
module rgb_to_yuv420_converter
  import rgbyuv_pkg::*;
#(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           luma,
  output logic                 chroma_valid,
  output logic [7:0]           cb,
  output logic [7:0]           cr,
  output logic                 end_of_frame
);

  stage1_t s1;
  psum_t   line_data;
  logic    s1_take;

  // counters, config and line store
  rgbyuv_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .s1_take  (s1_take),
    .s1       (s1),
    .line_data(line_data)
  );

  // color math and output register
  rgbyuv_color u_color (
    .clk         (clk),
    .rst         (rst),
    .s1          (s1),
    .line_data   (line_data),
    .s1_take     (s1_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .luma        (luma),
    .chroma_valid(chroma_valid),
    .cb          (cb),
    .cr          (cr),
    .end_of_frame(end_of_frame)
  );

endmodule
